// ===== rtl/slc_pkg.sv =====
// ----------------------------------------------------------------------------
// slc_pkg
// Shared constants and types for the set-associative LRU cache lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package slc_pkg;

   // Default geometry
   localparam int MAX_SET_BITS_DEF = 6;
   localparam int MAX_WAYS_DEF     = 8;

   // Configuration register indexes
   localparam logic [1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [1:0] CSR_WAYS       = 2'd2;

   // Lookup outcome codes
   typedef enum logic [1:0] {
      OUT_HIT   = 2'd0,
      OUT_FILL  = 2'd1,
      OUT_EVICT = 2'd2
   } outcome_type;

   // Back end sequencer states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK
   } back_state_type;

   // Status from back end to front end
   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

`default_nettype wire

// ===== rtl/slc_front.sv =====
// ----------------------------------------------------------------------------
// slc_front
// Splits each request address into set index and tag and queues it.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_front #(
   parameter int MAX_SET_BITS = slc_pkg::MAX_SET_BITS_DEF,
   parameter int MAX_WAYS     = slc_pkg::MAX_WAYS_DEF,
   parameter int SET_W        = (MAX_SET_BITS < 1) ? 1 : MAX_SET_BITS,
   parameter int CNT_W        = $clog2(MAX_WAYS + 1)
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire  [63:0]                req_address,
   input  wire  [2:0]                 cfg_set_bits,
   input  wire  [5:0]                 cfg_block_bits,
   input  wire  [3:0]                 cfg_ways,
   input  slc_pkg::back_status_type   status,
   output logic                       q_valid,
   input  wire                        q_pop,
   output logic [SET_W-1:0]           q_set,
   output logic [63:0]                q_tag,
   output logic [CNT_W-1:0]           q_ways
);
   import slc_pkg::*;

   logic [3:0]       sb;
   logic [6:0]       shift_amt;
   logic [SET_W-1:0] set_idx;
   logic [63:0]      tag;
   logic [CNT_W-1:0] ways;
   logic             push;

   logic [SET_W-1:0] set_ff [2];
   logic [63:0]      tag_ff [2];
   logic [CNT_W-1:0] ways_ff [2];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;

   // Classify: clamp config, extract set and tag
   always_comb begin
      sb = ({1'b0, cfg_set_bits} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
                                                     : {1'b0, cfg_set_bits};
      shift_amt = 7'(cfg_block_bits) + 7'(sb);
      set_idx = SET_W'(req_address >> cfg_block_bits) & ~({SET_W{1'b1}} << sb);
      tag = shift_amt[6] ? 64'd0 : (req_address >> shift_amt[5:0]);
      if (cfg_ways == 4'd0) begin
         ways = CNT_W'(1);
      end else if ({1'b0, cfg_ways} > 5'(MAX_WAYS)) begin
         ways = CNT_W'(MAX_WAYS);
      end else begin
         ways = CNT_W'(cfg_ways);
      end
   end

   // Two-entry request queue
   assign req_stall = (cnt_ff == 2'd2) || status.clearing;
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_set     = set_ff[rp_ff];
   assign q_tag     = tag_ff[rp_ff];
   assign q_ways    = ways_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = q_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         set_ff[wp_ff]  <= set_idx;
         tag_ff[wp_ff]  <= tag;
         ways_ff[wp_ff] <= ways;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/slc_back.sv =====
// ----------------------------------------------------------------------------
// slc_back
// Reads a set row, does tag compare and LRU update, writes the row back.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_back #(
   parameter int MAX_SET_BITS = slc_pkg::MAX_SET_BITS_DEF,
   parameter int MAX_WAYS     = slc_pkg::MAX_WAYS_DEF,
   parameter int SET_W        = (MAX_SET_BITS < 1) ? 1 : MAX_SET_BITS,
   parameter int CNT_W        = $clog2(MAX_WAYS + 1)
) (
   input  wire                        clock,
   input  wire                        reset,
   output slc_pkg::back_status_type   status,
   input  wire                        q_valid,
   output logic                       q_pop,
   input  wire  [SET_W-1:0]           q_set,
   input  wire  [63:0]                q_tag,
   input  wire  [CNT_W-1:0]           q_ways,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic [1:0]                 rsp_outcome,
   output logic [2:0]                 rsp_way_used,
   output logic [31:0]                rsp_hit_total,
   output logic [31:0]                rsp_miss_total,
   output logic [31:0]                rsp_eviction_total
);
   import slc_pkg::*;

   localparam int NUM_SETS = 1 << MAX_SET_BITS;
   localparam int RANK_W   = (MAX_WAYS < 2) ? 1 : $clog2(MAX_WAYS);
   localparam int WAY_W    = RANK_W;
   localparam logic [SET_W-1:0]  LAST_SET = SET_W'(NUM_SETS - 1);
   localparam logic [RANK_W-1:0] TOP_RANK = RANK_W'(MAX_WAYS - 1);

   // Set row memories
   logic [MAX_WAYS-1:0]        valid_mem [NUM_SETS];
   logic [MAX_WAYS*RANK_W-1:0] rank_mem  [NUM_SETS];
   logic [MAX_WAYS*64-1:0]     tag_mem   [NUM_SETS];

   logic [MAX_WAYS-1:0]        rd_valid_ff;
   logic [MAX_WAYS*RANK_W-1:0] rd_rank_ff;
   logic [MAX_WAYS*64-1:0]     rd_tag_ff;

   back_state_type state_ff, state_in;
   logic [SET_W-1:0] clr_ff, clr_in;
   logic [SET_W-1:0] set_ff;
   logic [63:0]      tag_ff;
   logic [CNT_W-1:0] ways_ff;

   logic                       rd_en, wr_en;
   logic [SET_W-1:0]           wr_addr;
   logic [MAX_WAYS-1:0]        wr_valid;
   logic [MAX_WAYS*RANK_W-1:0] wr_rank;
   logic [MAX_WAYS*64-1:0]     wr_tag;

   logic              hit, empty_found, load;
   logic [WAY_W-1:0]  hit_way, empty_way, victim, way;
   logic [RANK_W-1:0] best;
   logic [RANK_W:0]   limit;
   logic [RANK_W-1:0] rk;
   outcome_type       outcome;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  outcome_ff;
   logic [2:0]  way_ff;
   logic [31:0] hits_ff, hits_in, miss_ff, miss_in, evict_ff, evict_in;

   assign status.clearing = (state_ff == ST_CLEAR);

   // Memory read and write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_valid_ff <= valid_mem[q_set];
         rd_rank_ff  <= rank_mem[q_set];
         rd_tag_ff   <= tag_mem[q_set];
      end
      if (wr_en) begin
         valid_mem[wr_addr] <= wr_valid;
         rank_mem[wr_addr]  <= wr_rank;
         tag_mem[wr_addr]   <= wr_tag;
      end
   end

   // Lookup: hit search, first empty way, LRU victim
   always_comb begin
      hit         = 1'b0;
      hit_way     = '0;
      empty_found = 1'b0;
      empty_way   = '0;
      victim      = '0;
      best        = '0;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (CNT_W'(i) < ways_ff) begin
            if (!hit && rd_valid_ff[i] && rd_tag_ff[i*64 +: 64] == tag_ff) begin
               hit     = 1'b1;
               hit_way = WAY_W'(i);
            end
            if (!empty_found && !rd_valid_ff[i]) begin
               empty_found = 1'b1;
               empty_way   = WAY_W'(i);
            end
            if (rd_rank_ff[i*RANK_W +: RANK_W] > best) begin
               best   = rd_rank_ff[i*RANK_W +: RANK_W];
               victim = WAY_W'(i);
            end
         end
      end
      if (hit) begin
         way     = hit_way;
         outcome = OUT_HIT;
         limit   = {1'b0, rd_rank_ff[hit_way*RANK_W +: RANK_W]};
      end else if (empty_found) begin
         way     = empty_way;
         outcome = OUT_FILL;
         limit   = (RANK_W+1)'(MAX_WAYS);
      end else begin
         way     = victim;
         outcome = OUT_EVICT;
         limit   = (RANK_W+1)'(MAX_WAYS);
      end
   end

   // Row update: age, make newest, fill on miss
   always_comb begin
      wr_valid = rd_valid_ff;
      wr_rank  = rd_rank_ff;
      wr_tag   = rd_tag_ff;
      for (int i = 0; i < MAX_WAYS; i++) begin
         rk = rd_rank_ff[i*RANK_W +: RANK_W];
         if (CNT_W'(i) < ways_ff && WAY_W'(i) != way && rd_valid_ff[i]
             && {1'b0, rk} < limit && rk < TOP_RANK) begin
            wr_rank[i*RANK_W +: RANK_W] = rk + RANK_W'(1);
         end
      end
      wr_rank[way*RANK_W +: RANK_W] = '0;
      if (!hit) begin
         wr_valid[way]          = 1'b1;
         wr_tag[way*64 +: 64]   = tag_ff;
      end
      if (state_ff == ST_CLEAR) begin
         wr_valid = '0;
         wr_rank  = '0;
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      rd_en    = 1'b0;
      q_pop    = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = set_ff;
      load     = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + SET_W'(1);
            if (clr_ff == LAST_SET) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               rd_en    = 1'b1;
               q_pop    = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               wr_en    = 1'b1;
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Counters and output register next values
   always_comb begin
      hits_in  = hits_ff;
      miss_in  = miss_ff;
      evict_in = evict_ff;
      if (load) begin
         if (hit) begin
            hits_in = (hits_ff == '1) ? hits_ff : hits_ff + 32'd1;
         end else begin
            miss_in = (miss_ff == '1) ? miss_ff : miss_ff + 32'd1;
         end
         if (outcome == OUT_EVICT) begin
            evict_in = (evict_ff == '1) ? evict_ff : evict_ff + 32'd1;
         end
      end
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         hits_ff      <= '0;
         miss_ff      <= '0;
         evict_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hits_ff      <= hits_in;
         miss_ff      <= miss_in;
         evict_ff     <= evict_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request latch and result payload
   always_ff @(posedge clock) begin
      if (rd_en) begin
         set_ff  <= q_set;
         tag_ff  <= q_tag;
         ways_ff <= q_ways;
      end
      if (load) begin
         outcome_ff <= outcome;
         way_ff     <= 3'(way);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_outcome        = outcome_ff;
   assign rsp_way_used       = way_ff;
   assign rsp_hit_total      = hits_ff;
   assign rsp_miss_total     = miss_ff;
   assign rsp_eviction_total = evict_ff;

endmodule

`default_nettype wire

// ===== rtl/set_assoc_lru_cache_lookup.sv =====
// A request is queued, its set row is read, and the result is registered
// once no earlier response is held by rsp_stall. A new request is read only
// after the set row (tags, valid bits, LRU ranks) of the last is written
// back. Reset: synchronous; then a clearing pass over all 2**MAX_SET_BITS
// sets (64 by default) wipes valid bits and ranks while requests are stalled.
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup
// Tag store of a set-associative cache with LRU replacement and hit, miss
// and eviction totals.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_lru_cache_lookup #(
   parameter int MAX_SET_BITS = slc_pkg::MAX_SET_BITS_DEF,
   parameter int MAX_WAYS     = slc_pkg::MAX_WAYS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [5:0]  csr_wdata,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [63:0] req_address,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_outcome,
   output logic [2:0]  rsp_way_used,
   output logic [31:0] rsp_hit_total,
   output logic [31:0] rsp_miss_total,
   output logic [31:0] rsp_eviction_total
);
   import slc_pkg::*;

   localparam int SET_W = (MAX_SET_BITS < 1) ? 1 : MAX_SET_BITS;
   localparam int CNT_W = $clog2(MAX_WAYS + 1);

   logic [2:0] set_bits_ff;
   logic [5:0] block_bits_ff;
   logic [3:0] ways_ff;

   back_status_type  status;
   logic             q_valid, q_pop;
   logic [SET_W-1:0] q_set;
   logic [63:0]      q_tag;
   logic [CNT_W-1:0] q_ways;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= 3'd0;
         block_bits_ff <= 6'd0;
         ways_ff       <= 4'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SET_BITS:   set_bits_ff   <= csr_wdata[2:0];
            CSR_BLOCK_BITS: block_bits_ff <= csr_wdata;
            CSR_WAYS:       ways_ff       <= csr_wdata[3:0];
            default:        ;
         endcase
      end
   end

   slc_front #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_address    (req_address),
      .cfg_set_bits   (set_bits_ff),
      .cfg_block_bits (block_bits_ff),
      .cfg_ways       (ways_ff),
      .status         (status),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_set          (q_set),
      .q_tag          (q_tag),
      .q_ways         (q_ways)
   );

   slc_back #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .status             (status),
      .q_valid            (q_valid),
      .q_pop              (q_pop),
      .q_set              (q_set),
      .q_tag              (q_tag),
      .q_ways             (q_ways),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_outcome        (rsp_outcome),
      .rsp_way_used       (rsp_way_used),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_eviction_total (rsp_eviction_total)
   );

endmodule

`default_nettype wire

// ===== sim/set_assoc_lru_cache_lookup_tb.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup_tb
// Drives address requests into the LRU tag store under several geometries
// and handshake patterns, predicts each lookup result in a local copy of
// the tag store and compares every response field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module set_assoc_lru_cache_lookup_tb;
   import slc_pkg::*;

   localparam int SETS_MAX  = 1 << MAX_SET_BITS_DEF;
   localparam int WAYS_MAX  = MAX_WAYS_DEF;
   localparam int CYCLE_CAP = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_SET_BITS;
   logic [5:0]  csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_address = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_outcome;
   logic [2:0]  rsp_way_used;
   logic [31:0] rsp_hit_total;
   logic [31:0] rsp_miss_total;
   logic [31:0] rsp_eviction_total;

   set_assoc_lru_cache_lookup uut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_address(req_address),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_outcome(rsp_outcome), .rsp_way_used(rsp_way_used),
      .rsp_hit_total(rsp_hit_total), .rsp_miss_total(rsp_miss_total),
      .rsp_eviction_total(rsp_eviction_total)
   );

   always #2 clock = ~clock;

   typedef struct packed {
      outcome_type outcome;
      logic [2:0]  way;
      logic [31:0] hits;
      logic [31:0] misses;
      logic [31:0] evicts;
   } lookup_result_type;

   // local copy of the tag store and geometry
   logic [2:0]  set_bits_q;
   logic [5:0]  block_bits_q;
   logic [3:0]  ways_q;
   logic        tag_valid [SETS_MAX*WAYS_MAX];
   logic [63:0] tag_store [SETS_MAX*WAYS_MAX];
   logic [2:0]  age_rank  [SETS_MAX*WAYS_MAX];
   logic [31:0] hit_count, miss_count, evict_count;

   lookup_result_type pending_results[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_off = 1'b0;
   int hold_cycles = 0;

   function automatic logic [31:0] sat_inc(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   // age valid active lines ranked below limit, then make way w newest
   function automatic void promote_way(int base, int ways, int w, int limit);
      for (int i = 0; i < ways; i++)
         if (i != w && tag_valid[base+i] && age_rank[base+i] < limit &&
             age_rank[base+i] < WAYS_MAX-1)
            age_rank[base+i] = age_rank[base+i] + 3'd1;
      age_rank[base+w] = '0;
   endfunction

   function automatic lookup_result_type predict_lookup(logic [63:0] addr);
      lookup_result_type r;
      int sb, ways, shift, set_idx, base, w, best;
      logic [63:0] tag;
      bit found;
      sb = (set_bits_q > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : set_bits_q;
      ways = (ways_q == 0) ? 1 : ways_q;
      if (ways > WAYS_MAX) ways = WAYS_MAX;
      shift = block_bits_q + sb;
      set_idx = int'((addr >> block_bits_q) & ((64'd1 << sb) - 64'd1));
      tag = (shift >= 64) ? 64'd0 : (addr >> shift);
      base = set_idx * WAYS_MAX;
      found = 0;
      w = 0;
      for (int i = 0; i < ways && !found; i++)
         if (tag_valid[base+i] && tag_store[base+i] == tag) begin
            w = i;
            found = 1;
         end
      if (found) begin
         r.outcome = OUT_HIT;
         promote_way(base, ways, w, age_rank[base+w]);
         hit_count = sat_inc(hit_count);
      end else begin
         for (int i = 0; i < ways && !found; i++)
            if (!tag_valid[base+i]) begin
               w = i;
               found = 1;
            end
         if (found) begin
            r.outcome = OUT_FILL;
         end else begin
            best = 0;
            w = 0;
            for (int i = 0; i < ways; i++)
               if (age_rank[base+i] > best) begin
                  best = age_rank[base+i];
                  w = i;
               end
            r.outcome = OUT_EVICT;
            evict_count = sat_inc(evict_count);
         end
         promote_way(base, ways, w, WAYS_MAX);
         tag_valid[base+w] = 1'b1;
         tag_store[base+w] = tag;
         miss_count = sat_inc(miss_count);
      end
      r.way = w[2:0];
      r.hits = hit_count;
      r.misses = miss_count;
      r.evicts = evict_count;
      return r;
   endfunction

   // register write, block idle
   task automatic write_csr(logic [1:0] idx, logic [5:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SET_BITS:   set_bits_q = val[2:0];
         CSR_BLOCK_BITS: block_bits_q = val;
         default:        ways_q = val[3:0];
      endcase
   endtask

   task automatic set_geometry(logic [5:0] sb, logic [5:0] bb, logic [5:0] wy);
      write_csr(CSR_SET_BITS, sb);
      write_csr(CSR_BLOCK_BITS, bb);
      write_csr(CSR_WAYS, wy);
   endtask

   // stop sending, wait for all responses, then let the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // send one request; prediction is taken at acceptance
   task automatic send_request(logic [63:0] addr);
      if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99, 0) < send_idle_pct) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_address <= addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(predict_lookup(addr));
      @(negedge clock);
   endtask

   function automatic logic [63:0] rand_addr64();
      return {$urandom(), $urandom()};
   endfunction

   // receiver stall, with one long hold-off counted here
   always @(negedge clock) begin
      if (hold_off) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles + 1;
         if (hold_cycles >= 60) hold_off <= 1'b0;
      end else begin
         rsp_stall <= (recv_stall_pct != 0) && ($urandom_range(99, 0) < recv_stall_pct);
      end
   end

   // response checker
   always @(posedge clock) begin
      lookup_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response at cycle %0d", cycle_count);
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_outcome !== exp_r.outcome || rsp_way_used !== exp_r.way ||
                rsp_hit_total !== exp_r.hits || rsp_miss_total !== exp_r.misses ||
                rsp_eviction_total !== exp_r.evicts) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch: exp out=%0d way=%0d h=%0d m=%0d e=%0d",
                            " got %0d %0d %0d %0d %0d"},
                     exp_r.outcome, exp_r.way, exp_r.hits, exp_r.misses, exp_r.evicts,
                     rsp_outcome, rsp_way_used, rsp_hit_total, rsp_miss_total,
                     rsp_eviction_total);
            end
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("[set_assoc_lru_cache_lookup] ERROR");
         $finish;
      end
   end

   // directed rows: expected outcome/way given where obvious, else predictor
   typedef struct {
      logic [63:0] addr;
      bit          typed;
      outcome_type outcome;
      logic [2:0]  way;
   } dir_row_type;

   dir_row_type dir_rows[16];

   initial begin
      lookup_result_type p;
      logic [63:0] base_addr;
      set_bits_q = 0;
      block_bits_q = 0;
      ways_q = 1;
      hit_count = 0;
      miss_count = 0;
      evict_count = 0;
      for (int i = 0; i < SETS_MAX*WAYS_MAX; i++) begin
         tag_valid[i] = 0;
         tag_store[i] = 0;
         age_rank[i] = 0;
      end
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // reset geometry: one set, one way
      dir_rows[0] = '{64'h0, 1, OUT_FILL, 3'd0};
      dir_rows[1] = '{64'h0, 1, OUT_HIT, 3'd0};
      dir_rows[2] = '{64'hFFFF_FFFF_FFFF_FFFF, 1, OUT_EVICT, 3'd0};
      dir_rows[3] = '{64'hFFFF_FFFF_FFFF_FFFF, 1, OUT_HIT, 3'd0};
      // typed rows are first checked against the predictor
      for (int i = 0; i < 4; i++) begin
         p = predict_lookup(dir_rows[i].addr);
         if (dir_rows[i].typed && (p.outcome != dir_rows[i].outcome ||
                                   p.way != dir_rows[i].way)) begin
            mismatch_count++;
            $display("directed row %0d disagrees with predictor", i);
         end
      end
      // clear local state again, then send the table through the handshake
      for (int i = 0; i < SETS_MAX*WAYS_MAX; i++) begin
         tag_valid[i] = 0;
         age_rank[i] = 0;
      end
      hit_count = 0;
      miss_count = 0;
      evict_count = 0;
      for (int i = 0; i < 4; i++) send_request(dir_rows[i].addr);
      drain();

      // widest geometry and edge cases: 4-way LRU walk, then wide shift, zero ways
      set_geometry(6'd6, 6'd4, 6'd4);
      for (int i = 0; i < 6; i++) send_request({32'(i), 32'h0000_0010});
      send_request({32'd1, 32'h0000_0010});
      send_request({32'd5, 32'h0000_0010});
      drain();
      set_geometry(6'd7, 6'd58, 6'd15);
      send_request(64'hFFFF_FFFF_FFFF_FFFF);
      send_request(64'h0123_4567_89AB_CDEF);
      send_request(64'h8000_0000_0000_0000);
      drain();
      set_geometry(6'd0, 6'd63, 6'd0);
      send_request(64'h0);
      send_request(64'hFFFF_FFFF_FFFF_FFFF);
      drain();

      // random phases across geometries and idling patterns
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
         endcase
         set_geometry(6'($urandom_range(ph == 7 ? 0 : 6, 0)),
                      6'(ph == 5 ? 58 : $urandom_range(12, 0)),
                      6'(ph == 6 ? 8 : $urandom_range(8, 1)));
         base_addr = rand_addr64();
         for (int i = 0; i < 105; i++) begin
            // mostly a small working set so hits and evictions recur
            if ($urandom_range(9, 0) < 8)
               send_request(base_addr ^ (64'($urandom_range(47, 0)) << block_bits_q));
            else
               send_request(rand_addr64());
            // long receiver hold-off while requests keep coming
            if (ph == 2 && i == 20) hold_off = 1'b1;
            if (ph == 3 && i == 50) drain();
         end
         drain();
      end

      if (mismatch_count == 0)
         $display("[set_assoc_lru_cache_lookup] OK");
      else
         $display("[set_assoc_lru_cache_lookup] ERROR");
      $finish;
   end

endmodule
